>>> rtl/cmtc_pkg.sv
// Package for the clock motor tick controller.
// Operation and register codes, reset defaults and the result struct.
// No dependencies.
package cmtc_pkg;

    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_READ      = 3'd1,
        OP_TICK      = 3'd2,
        OP_PULSE_END = 3'd3,
        OP_DELAY_END = 3'd4,
        OP_PWR_FAIL  = 3'd5,
        OP_PWR_GOOD  = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        REG_ID       = 4'd0,
        REG_POSITION = 4'd1,
        REG_ADJUST   = 4'd2,
        REG_TICK_MS  = 4'd3,
        REG_TICK_DTY = 4'd4,
        REG_ADJ_MS   = 4'd5,
        REG_ADJ_DTY  = 4'd6,
        REG_DELAY    = 4'd7,
        REG_CONTROL  = 4'd8,
        REG_STATUS   = 4'd9
    } t_reg;

    typedef enum logic {
        CFG_DIAL = 1'b0,
        CFG_ID   = 1'b1
    } t_cfg;

    localparam logic [15:0] DIAL_RESET     = 16'd43200;
    localparam logic [15:0] POS_RESET      = 16'd43199;
    localparam logic [7:0]  ID_RESET       = 8'd0;
    localparam logic [7:0]  TICK_MS_RESET  = 8'd12;
    localparam logic [7:0]  TICK_DTY_RESET = 8'd60;
    localparam logic [7:0]  ADJ_MS_RESET   = 8'd16;
    localparam logic [7:0]  ADJ_DTY_RESET  = 8'd90;
    localparam logic [7:0]  GAP_MS_RESET   = 8'd20;
    localparam int          ENABLE_BIT     = 7;
    localparam logic [15:0] STEPS_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [15:0] read_data;
        logic        pulse_start;
        logic [7:0]  pulse_ms;
        logic [7:0]  pulse_duty;
        logic        coil_select;
        logic        delay_start;
        logic [7:0]  delay_ms;
    } t_result;

endpackage

>>> rtl/cmtc_core.sv
// Controller state and the per-item next-state and result logic.
// Depends on cmtc_pkg.
module cmtc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [2:0]           i_operation,
    input  logic [3:0]           i_reg_select,
    input  logic [15:0]          i_write_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output cmtc_pkg::t_result    o_result
);

    logic [15:0] r_dial, r_pos, r_steps;
    logic [7:0]  r_id, r_tick_ms, r_tick_dty, r_adj_ms, r_adj_dty, r_gap_ms;
    logic [7:0]  r_ctrl, r_saved;
    logic        r_phase, r_adjusting, r_pwr_lost;

    logic [15:0] n_pos, n_steps;
    logic [7:0]  n_tick_ms, n_tick_dty, n_adj_ms, n_adj_dty, n_gap_ms;
    logic [7:0]  n_ctrl, n_saved;
    logic        n_phase, n_adjusting, n_pwr_lost;

    logic [16:0] pos_inc;
    logic [15:0] pos_adv;
    logic [7:0]  wr_byte;
    cmtc_pkg::t_result res;

    assign pos_inc = {1'b0, r_pos} + 17'd1;
    // Wrap at the dial size; a position beyond the dial also wraps to zero.
    assign pos_adv = (pos_inc >= {1'b0, r_dial}) ? 16'd0 : pos_inc[15:0];
    assign wr_byte = i_write_data[7:0];

    always_comb begin
        n_pos       = r_pos;
        n_steps     = r_steps;
        n_tick_ms   = r_tick_ms;
        n_tick_dty  = r_tick_dty;
        n_adj_ms    = r_adj_ms;
        n_adj_dty   = r_adj_dty;
        n_gap_ms    = r_gap_ms;
        n_ctrl      = r_ctrl;
        n_saved     = r_saved;
        n_phase     = r_phase;
        n_adjusting = r_adjusting;
        n_pwr_lost  = r_pwr_lost;
        res         = '0;

        unique case (cmtc_pkg::t_op'(i_operation))
            cmtc_pkg::OP_WRITE: begin
                unique case (cmtc_pkg::t_reg'(i_reg_select))
                    cmtc_pkg::REG_POSITION: n_pos      = i_write_data;
                    cmtc_pkg::REG_ADJUST:   n_steps    = i_write_data;
                    cmtc_pkg::REG_TICK_MS:  n_tick_ms  = wr_byte;
                    cmtc_pkg::REG_TICK_DTY: n_tick_dty = wr_byte;
                    cmtc_pkg::REG_ADJ_MS:   n_adj_ms   = wr_byte;
                    cmtc_pkg::REG_ADJ_DTY:  n_adj_dty  = wr_byte;
                    cmtc_pkg::REG_DELAY:    n_gap_ms   = wr_byte;
                    cmtc_pkg::REG_CONTROL:  n_ctrl     = wr_byte;
                    default: ;
                endcase
            end
            cmtc_pkg::OP_READ: begin
                unique case (cmtc_pkg::t_reg'(i_reg_select))
                    cmtc_pkg::REG_ID:       res.read_data = {8'd0, r_id};
                    cmtc_pkg::REG_POSITION: res.read_data = r_pos;
                    cmtc_pkg::REG_ADJUST:   res.read_data = r_steps;
                    cmtc_pkg::REG_TICK_MS:  res.read_data = {8'd0, r_tick_ms};
                    cmtc_pkg::REG_TICK_DTY: res.read_data = {8'd0, r_tick_dty};
                    cmtc_pkg::REG_ADJ_MS:   res.read_data = {8'd0, r_adj_ms};
                    cmtc_pkg::REG_ADJ_DTY:  res.read_data = {8'd0, r_adj_dty};
                    cmtc_pkg::REG_DELAY:    res.read_data = {8'd0, r_gap_ms};
                    cmtc_pkg::REG_CONTROL:  res.read_data = {8'd0, r_ctrl};
                    cmtc_pkg::REG_STATUS:   res.read_data = {15'd0, r_phase};
                    default:                res.read_data = 16'd0;
                endcase
            end
            cmtc_pkg::OP_TICK: begin
                if (r_ctrl[cmtc_pkg::ENABLE_BIT] && r_steps == 16'd0) begin
                    n_pos           = pos_adv;
                    res.pulse_start = 1'b1;
                    res.pulse_ms    = r_tick_ms;
                    res.pulse_duty  = r_tick_dty;
                end else if (r_steps != 16'd0) begin
                    // enabled tick while adjusting adds one more step, saturating at STEPS_MAX
                    if (r_ctrl[cmtc_pkg::ENABLE_BIT] && r_steps != cmtc_pkg::STEPS_MAX)
                        n_steps = r_steps + 16'd1;
                    if (!r_adjusting) begin
                        n_adjusting     = 1'b1;
                        n_pos           = pos_adv;
                        res.pulse_start = 1'b1;
                        res.pulse_ms    = r_tick_ms;
                        res.pulse_duty  = r_tick_dty;
                    end
                end
            end
            cmtc_pkg::OP_PULSE_END: begin
                n_phase = ~r_phase;
                if (r_steps != 16'd0)
                    n_steps = r_steps - 16'd1;
                if (r_steps > 16'd1) begin
                    res.delay_start = 1'b1;
                    res.delay_ms    = r_gap_ms;
                end else begin
                    n_adjusting = 1'b0;
                end
            end
            cmtc_pkg::OP_DELAY_END: begin
                n_pos           = pos_adv;
                res.pulse_start = 1'b1;
                res.pulse_ms    = (r_steps == 16'd1) ? r_tick_ms  : r_adj_ms;
                res.pulse_duty  = (r_steps == 16'd1) ? r_tick_dty : r_adj_dty;
            end
            cmtc_pkg::OP_PWR_FAIL: begin
                if (!r_pwr_lost) begin
                    n_pwr_lost                    = 1'b1;
                    n_saved                       = r_ctrl;
                    n_ctrl[cmtc_pkg::ENABLE_BIT]  = 1'b0;
                    if (r_steps > 16'd1)
                        n_steps = 16'd1;
                end
            end
            cmtc_pkg::OP_PWR_GOOD: begin
                if (r_pwr_lost) begin
                    n_pwr_lost = 1'b0;
                    n_ctrl     = r_saved;
                end
            end
            default: ;
        endcase

        res.coil_select = n_phase;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dial      <= cmtc_pkg::DIAL_RESET;
            r_id        <= cmtc_pkg::ID_RESET;
            r_pos       <= cmtc_pkg::POS_RESET;
            r_steps     <= 16'd1;
            r_tick_ms   <= cmtc_pkg::TICK_MS_RESET;
            r_tick_dty  <= cmtc_pkg::TICK_DTY_RESET;
            r_adj_ms    <= cmtc_pkg::ADJ_MS_RESET;
            r_adj_dty   <= cmtc_pkg::ADJ_DTY_RESET;
            r_gap_ms    <= cmtc_pkg::GAP_MS_RESET;
            r_ctrl      <= 8'd0;
            r_saved     <= 8'd0;
            r_phase     <= 1'b0;
            r_adjusting <= 1'b0;
            r_pwr_lost  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (cmtc_pkg::t_cfg'(i_cfg_index))
                    cmtc_pkg::CFG_DIAL: r_dial <= i_cfg_data;
                    cmtc_pkg::CFG_ID:   r_id   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_pos       <= n_pos;
                r_steps     <= n_steps;
                r_tick_ms   <= n_tick_ms;
                r_tick_dty  <= n_tick_dty;
                r_adj_ms    <= n_adj_ms;
                r_adj_dty   <= n_adj_dty;
                r_gap_ms    <= n_gap_ms;
                r_ctrl      <= n_ctrl;
                r_saved     <= n_saved;
                r_phase     <= n_phase;
                r_adjusting <= n_adjusting;
                r_pwr_lost  <= n_pwr_lost;
            end
        end
    end

endmodule

>>> rtl/cmtc_out_reg.sv
// Result register with valid/ready toward the consumer.
// Depends on cmtc_pkg.
module cmtc_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  cmtc_pkg::t_result    i_result,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic                 o_free,
    output cmtc_pkg::t_result    o_result
);

    logic              r_valid;
    cmtc_pkg::t_result r_result;

    // free when empty or draining this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> rtl/clock_motor_tick_controller.sv
// Clock motor tick controller: one result item per input item.
// Latency: a result is valid the cycle after its input item is accepted.
// Throughput: one item per cycle while results are taken; the single result
// register sets the pace: a new item is taken in the cycle the held one is.
// Reset (i_rst_n low, synchronous) restores all registers to their defaults
// and empties the result register.
module clock_motor_tick_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_reg_select,
    input  logic [15:0] i_write_data,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_read_data,
    output logic        o_pulse_start,
    output logic [7:0]  o_pulse_ms,
    output logic [7:0]  o_pulse_duty,
    output logic        o_coil_select,
    output logic        o_delay_start,
    output logic [7:0]  o_delay_ms
);

    logic              accept;
    logic              out_free;
    cmtc_pkg::t_result core_res;
    cmtc_pkg::t_result held_res;

    // Input is taken whenever the result register can take the result.
    assign o_in_ready = out_free;
    assign accept     = i_in_valid && out_free;

    // State and all per-item decisions: one pass of compares and
    // increments from the input ports to the result register.
    cmtc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_result     (core_res)
    );

    // Result register decouples the two handshakes.
    cmtc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (core_res),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (held_res)
    );

    assign o_read_data   = held_res.read_data;
    assign o_pulse_start = held_res.pulse_start;
    assign o_pulse_ms    = held_res.pulse_ms;
    assign o_pulse_duty  = held_res.pulse_duty;
    assign o_coil_select = held_res.coil_select;
    assign o_delay_start = held_res.delay_start;
    assign o_delay_ms    = held_res.delay_ms;

endmodule

>>> rtl/cmtc_checker.sv
// Port-level checks for the clock motor tick controller, bound to the top.
// Depends only on the top level's ports.
module cmtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_read_data,
    input logic        o_pulse_start,
    input logic [7:0]  o_pulse_ms,
    input logic [7:0]  o_pulse_duty,
    input logic        o_delay_start
);

    // a held result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // every accepted item shows a result next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item gave no result");

    // a pulse and a delay never start from the same item
    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_pulse_start && o_delay_start))
        else $error("pulse and delay started together");

    // pulse settings are zero unless a pulse starts
    a_pulse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pulse_start |-> o_pulse_ms == 8'd0 && o_pulse_duty == 8'd0)
        else $error("pulse settings without pulse");

    // read data only on items that start nothing
    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_pulse_start || o_delay_start) |-> o_read_data == 16'd0)
        else $error("read data on a start item");

endmodule

bind clock_motor_tick_controller cmtc_checker u_cmtc_checker (.*);

>>> test/tb.sv
// Self-checking testbench for clock_motor_tick_controller.
// Holds a predictor of the hand/coil logic, drives items through the handshakes
// and checks every result item. Needs rtl/cmtc_pkg.sv and the top-level RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package has no member for: the spare operation and a register
    // index past the end of the map.
    localparam logic [2:0] OP_NONE  = 3'd7;
    localparam logic [3:0] REG_NONE = 4'd15;

    // -------------------------------------------------------------------------
    // Predictor and store of expected result items
    // -------------------------------------------------------------------------
    class motor_predictor;
        // configuration
        logic [15:0] dial;
        logic [7:0]  id_byte;
        // block state
        logic [15:0] hand_pos;
        logic [15:0] steps;
        logic [7:0]  tick_ms, tick_duty, adj_ms, adj_duty, gap_ms;
        logic [7:0]  ctrl, saved_ctrl;
        logic        phase, adjusting, power_down;
        // result under construction and the results still owed by the block
        cmtc_pkg::t_result res;
        cmtc_pkg::t_result expected_items[$];
        int          mismatches;

        function new();
            dial       = cmtc_pkg::DIAL_RESET;
            id_byte    = cmtc_pkg::ID_RESET;
            hand_pos   = cmtc_pkg::POS_RESET;
            steps      = 16'd1;
            tick_ms    = cmtc_pkg::TICK_MS_RESET;
            tick_duty  = cmtc_pkg::TICK_DTY_RESET;
            adj_ms     = cmtc_pkg::ADJ_MS_RESET;
            adj_duty   = cmtc_pkg::ADJ_DTY_RESET;
            gap_ms     = cmtc_pkg::GAP_MS_RESET;
            ctrl       = '0;
            saved_ctrl = '0;
            phase      = 1'b0;
            adjusting  = 1'b0;
            power_down = 1'b0;
            mismatches = 0;
        endfunction

        function void apply_cfg(cmtc_pkg::t_cfg idx, logic [15:0] data);
            if (idx == cmtc_pkg::CFG_DIAL)
                dial = data;
            else
                id_byte = data[7:0];
        endfunction

        // One hand step: wrap at the dial size (a zero dial always gives zero)
        function void step_hand(logic [7:0] ms, logic [7:0] duty);
            logic [16:0] nxt;
            nxt = {1'b0, hand_pos} + 17'd1;
            if (nxt >= {1'b0, dial})
                nxt = '0;
            hand_pos        = nxt[15:0];
            res.pulse_start = 1'b1;
            res.pulse_ms    = ms;
            res.pulse_duty  = duty;
        endfunction

        function void start_adjust();
            if (!adjusting) begin
                adjusting = 1'b1;
                step_hand(tick_ms, tick_duty);
            end
        endfunction

        function logic [15:0] reg_value(logic [3:0] sel);
            case (sel)
                cmtc_pkg::REG_ID:       return {8'd0, id_byte};
                cmtc_pkg::REG_POSITION: return hand_pos;
                cmtc_pkg::REG_ADJUST:   return steps;
                cmtc_pkg::REG_TICK_MS:  return {8'd0, tick_ms};
                cmtc_pkg::REG_TICK_DTY: return {8'd0, tick_duty};
                cmtc_pkg::REG_ADJ_MS:   return {8'd0, adj_ms};
                cmtc_pkg::REG_ADJ_DTY:  return {8'd0, adj_duty};
                cmtc_pkg::REG_DELAY:    return {8'd0, gap_ms};
                cmtc_pkg::REG_CONTROL:  return {8'd0, ctrl};
                cmtc_pkg::REG_STATUS:   return {15'd0, phase};
                default:                return 16'd0;
            endcase
        endfunction

        function void reg_write(logic [3:0] sel, logic [15:0] v);
            case (sel)
                cmtc_pkg::REG_POSITION: hand_pos  = v;
                cmtc_pkg::REG_ADJUST:   steps     = v;
                cmtc_pkg::REG_TICK_MS:  tick_ms   = v[7:0];
                cmtc_pkg::REG_TICK_DTY: tick_duty = v[7:0];
                cmtc_pkg::REG_ADJ_MS:   adj_ms    = v[7:0];
                cmtc_pkg::REG_ADJ_DTY:  adj_duty  = v[7:0];
                cmtc_pkg::REG_DELAY:    gap_ms    = v[7:0];
                cmtc_pkg::REG_CONTROL:  ctrl      = v[7:0];
                default: ;  // id, status and unmapped indexes ignore writes
            endcase
        endfunction

        // Called once per accepted input item; queues the one result it causes
        function void predict_item(logic [2:0] op, logic [3:0] sel, logic [15:0] data);
            res = '0;
            case (op)
                cmtc_pkg::OP_WRITE: reg_write(sel, data);
                cmtc_pkg::OP_READ:  res.read_data = reg_value(sel);
                cmtc_pkg::OP_TICK: begin
                    if (ctrl[cmtc_pkg::ENABLE_BIT]) begin
                        if (steps != 16'd0) begin
                            if (steps != cmtc_pkg::STEPS_MAX)
                                steps = steps + 16'd1;
                            start_adjust();
                        end else begin
                            step_hand(tick_ms, tick_duty);
                        end
                    end else if (steps != 16'd0) begin
                        start_adjust();
                    end
                end
                cmtc_pkg::OP_PULSE_END: begin
                    phase = ~phase;
                    if (steps != 16'd0) begin
                        steps = steps - 16'd1;
                        if (steps != 16'd0) begin
                            res.delay_start = 1'b1;
                            res.delay_ms    = gap_ms;
                        end else begin
                            adjusting = 1'b0;
                        end
                    end else begin
                        adjusting = 1'b0;
                    end
                end
                cmtc_pkg::OP_DELAY_END: begin
                    if (steps == 16'd1)
                        step_hand(tick_ms, tick_duty);
                    else
                        step_hand(adj_ms, adj_duty);
                end
                cmtc_pkg::OP_PWR_FAIL: begin
                    if (!power_down) begin
                        power_down                 = 1'b1;
                        saved_ctrl                 = ctrl;
                        ctrl[cmtc_pkg::ENABLE_BIT] = 1'b0;
                        if (steps > 16'd1)
                            steps = 16'd1;
                    end
                end
                cmtc_pkg::OP_PWR_GOOD: begin
                    if (power_down) begin
                        power_down = 1'b0;
                        ctrl       = saved_ctrl;
                    end
                end
                default: ;
            endcase
            res.coil_select = phase;
            expected_items.push_back(res);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // Called once per accepted result item
        function void compare_result(cmtc_pkg::t_result got);
            cmtc_pkg::t_result want;
            if (expected_items.size() == 0) begin
                mismatches++;
                $display("%0t ns: result item with none expected, expected none actual %h",
                         $time, got);
                return;
            end
            want = expected_items.pop_front();
            check_field("read_data",   want.read_data,   got.read_data);
            check_field("pulse_start", 16'(want.pulse_start), 16'(got.pulse_start));
            check_field("pulse_ms",    16'(want.pulse_ms),    16'(got.pulse_ms));
            check_field("pulse_duty",  16'(want.pulse_duty),  16'(got.pulse_duty));
            check_field("coil_select", 16'(want.coil_select), 16'(got.coil_select));
            check_field("delay_start", 16'(want.delay_start), 16'(got.delay_start));
            check_field("delay_ms",    16'(want.delay_ms),    16'(got.delay_ms));
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // -------------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        in_valid   = 1'b0;
    logic [2:0]  in_op      = '0;
    logic [3:0]  in_sel     = '0;
    logic [15:0] in_data    = '0;
    logic        cfg_we     = 1'b0;
    logic        cfg_index  = 1'b0;
    logic [15:0] cfg_data   = '0;
    logic        out_ready  = 1'b0;

    logic        o_in_ready, o_out_valid;
    logic [15:0] o_read_data;
    logic        o_pulse_start, o_coil_select, o_delay_start;
    logic [7:0]  o_pulse_ms, o_pulse_duty, o_delay_ms;

    motor_predictor sb;
    int          items_sent;
    int          send_gap_pct;   // chance in 100 that the sender idles a cycle
    int          recv_gap_pct;   // chance in 100 that the receiver stalls a cycle

    clock_motor_tick_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (in_op),
        .i_reg_select  (in_sel),
        .i_write_data  (in_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_read_data   (o_read_data),
        .o_pulse_start (o_pulse_start),
        .o_pulse_ms    (o_pulse_ms),
        .o_pulse_duty  (o_pulse_duty),
        .o_coil_select (o_coil_select),
        .o_delay_start (o_delay_start),
        .o_delay_ms    (o_delay_ms)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs a handshake
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: ready changes only at the falling edge, at the current stall rate
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Result monitor: a result item moves on a rising edge with valid and ready
    // high. Values are read before the block's own updates at that edge land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && out_ready)
            sb.compare_result({o_read_data, o_pulse_start, o_pulse_ms, o_pulse_duty,
                               o_coil_select, o_delay_start, o_delay_ms});
    end

    // -------------------------------------------------------------------------
    // Drivers
    // -------------------------------------------------------------------------

    // Offer one item; valid stays up with a fixed payload until it is taken.
    // Valid is left high afterwards so back-to-back items need no extra edge.
    task automatic send_item(input logic [2:0] op, input logic [3:0] sel,
                             input logic [15:0] data);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_sel   <= sel;
        in_data  <= data;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.predict_item(op, sel, data);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // Stop offering items and wait until every result item has come back.
    task automatic settle_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_items.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Only called while the block is idle
    task automatic cfg_write(input cmtc_pkg::t_cfg idx, input logic [15:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.apply_cfg(idx, data);
    endtask

    // Mostly mapped registers, now and then an unmapped index
    function automatic logic [3:0] pick_reg();
        if ($urandom_range(9) == 0)
            return 4'($urandom_range(15));
        return 4'($urandom_range(9));
    endfunction

    function automatic logic [15:0] any_data();
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // One catch-up run: load a step count, kick it off with a tick, then walk
    // pulse-done / delay-done until no steps remain or eight passes are done.
    task automatic adjust_burst();
        int guard;
        int pick;
        guard = 0;
        if ($urandom_range(3) == 0)
            send_item(cmtc_pkg::OP_WRITE, 4'(cmtc_pkg::REG_TICK_MS + $urandom_range(4)),
                      any_data());
        send_item(cmtc_pkg::OP_WRITE, cmtc_pkg::REG_ADJUST,
                  ($urandom_range(7) == 0) ? any_data() : 16'($urandom_range(4)));
        if ($urandom_range(1))
            send_item(cmtc_pkg::OP_WRITE, cmtc_pkg::REG_CONTROL, any_data());
        send_item(cmtc_pkg::OP_TICK, pick_reg(), any_data());
        while (sb.steps != 16'd0 && guard < 8) begin
            send_item(cmtc_pkg::OP_PULSE_END, pick_reg(), any_data());
            if (sb.steps != 16'd0) begin
                // occasional noise in the middle of the run
                if ($urandom_range(7) == 0) begin
                    pick = $urandom_range(2);
                    if (pick == 0)
                        send_item(cmtc_pkg::OP_TICK, pick_reg(), any_data());
                    else if (pick == 1)
                        send_item(cmtc_pkg::OP_READ, cmtc_pkg::REG_STATUS, any_data());
                    else
                        send_item(cmtc_pkg::OP_PWR_FAIL, pick_reg(), any_data());
                end
                send_item(cmtc_pkg::OP_DELAY_END, pick_reg(), any_data());
            end
            guard++;
        end
    endtask

    // Random traffic for one configuration; halfway through, the sender holds
    // off until the block has returned everything.
    task automatic run_traffic(input int count);
        int goal;
        int halfway;
        int r;
        bit drained;
        goal    = items_sent + count;
        halfway = items_sent + count / 2;
        drained = 1'b0;
        while (items_sent < goal) begin
            if (!drained && items_sent >= halfway) begin
                settle_results();
                drained = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 50)
                adjust_burst();
            else if (r < 65)
                send_item(cmtc_pkg::OP_READ, pick_reg(), any_data());
            else if (r < 78)
                send_item(cmtc_pkg::OP_WRITE, pick_reg(), any_data());
            else if (r < 85)
                send_item($urandom_range(1) ? cmtc_pkg::OP_PWR_FAIL : cmtc_pkg::OP_PWR_GOOD,
                          pick_reg(), any_data());
            else if (r < 92)
                send_item(cmtc_pkg::OP_TICK, pick_reg(), any_data());
            else if (r < 96)
                send_item(cmtc_pkg::OP_PULSE_END, pick_reg(), any_data());
            else if (r < 99)
                send_item(cmtc_pkg::OP_DELAY_END, pick_reg(), any_data());
            else
                send_item(OP_NONE, pick_reg(), any_data());
        end
    endtask

    // -------------------------------------------------------------------------
    // Test sequence
    // -------------------------------------------------------------------------
    initial begin
        logic [15:0] dial_set [6];
        logic [15:0] id_set   [6];
        sb           = new();
        items_sent   = 0;
        send_gap_pct = 19;
        recv_gap_pct = 56;

        // Synchronous reset, released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items, run against the reset configuration
        send_item(cmtc_pkg::OP_READ, cmtc_pkg::REG_ID, 16'h0000);
        send_item(cmtc_pkg::OP_READ, cmtc_pkg::REG_STATUS, 16'hFFFF);
        send_item(cmtc_pkg::OP_READ, REG_NONE, 16'hFFFF);      // unmapped read gives zero
        send_item(OP_NONE, cmtc_pkg::REG_POSITION, 16'hFFFF);  // spare op: coil only
        send_item(cmtc_pkg::OP_TICK, cmtc_pkg::REG_ID, 16'h0000);      // disabled tick
        send_item(cmtc_pkg::OP_DELAY_END, cmtc_pkg::REG_ID, 16'h0000); // delay done, no delay
        send_item(cmtc_pkg::OP_PULSE_END, cmtc_pkg::REG_ID, 16'h0000); // last step finishes
        send_item(cmtc_pkg::OP_PULSE_END, cmtc_pkg::REG_ID, 16'h0000); // pulse done, no pulse
        send_item(cmtc_pkg::OP_WRITE, cmtc_pkg::REG_CONTROL, 16'hFF80); // high byte dropped
        send_item(cmtc_pkg::OP_TICK, cmtc_pkg::REG_ID, 16'h0000);      // plain enabled tick
        send_item(cmtc_pkg::OP_WRITE, cmtc_pkg::REG_ADJUST, 16'hFFFF);
        send_item(cmtc_pkg::OP_TICK, cmtc_pkg::REG_ID, 16'h0000);      // step count saturates
        send_item(cmtc_pkg::OP_READ, cmtc_pkg::REG_ADJUST, 16'h0000);
        send_item(cmtc_pkg::OP_PWR_FAIL, cmtc_pkg::REG_ID, 16'h0000);  // enable cleared
        send_item(cmtc_pkg::OP_PWR_FAIL, cmtc_pkg::REG_ID, 16'h0000);  // second fail ignored
        send_item(cmtc_pkg::OP_READ, cmtc_pkg::REG_CONTROL, 16'h0000);
        send_item(cmtc_pkg::OP_PWR_GOOD, cmtc_pkg::REG_ID, 16'h0000);
        send_item(cmtc_pkg::OP_PWR_GOOD, cmtc_pkg::REG_ID, 16'h0000);  // restore, no fail
        send_item(cmtc_pkg::OP_WRITE, cmtc_pkg::REG_POSITION, 16'hFFFF); // hand past dial
        send_item(cmtc_pkg::OP_DELAY_END, cmtc_pkg::REG_ID, 16'h0000); // lands on zero
        send_item(cmtc_pkg::OP_WRITE, cmtc_pkg::REG_ID, 16'hFFFF);     // read-only target
        send_item(cmtc_pkg::OP_WRITE, cmtc_pkg::REG_STATUS, 16'hFFFF);
        send_item(cmtc_pkg::OP_WRITE, REG_NONE, 16'hFFFF);
        send_item(cmtc_pkg::OP_WRITE, cmtc_pkg::REG_ADJ_MS, 16'h00FF);
        send_item(cmtc_pkg::OP_READ, cmtc_pkg::REG_POSITION, 16'h0000);
        settle_results();

        // Six settings: dial extremes (one, zero, full scale), a tiny dial for
        // frequent wraps, a random one and the default; id extremes too.
        // Idle pattern: sender light / receiver heavy, then swapped, then none.
        dial_set = '{16'd1, 16'd0, 16'hFFFF, 16'd3,
                     16'($urandom_range(2, 60)), cmtc_pkg::DIAL_RESET};
        id_set   = '{16'h00FF, 16'h0000, any_data(), 16'h00A5, any_data(), any_data()};
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_gap_pct = 19;
                    recv_gap_pct = 56;
                end
                1: begin
                    send_gap_pct = 56;
                    recv_gap_pct = 19;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            cfg_write(cmtc_pkg::CFG_DIAL, dial_set[ph]);
            cfg_write(cmtc_pkg::CFG_ID, id_set[ph]);
            run_traffic(84);
            settle_results();
        end

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_items.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cmtc_pkg.sv
rtl/cmtc_core.sv
rtl/cmtc_out_reg.sv
rtl/clock_motor_tick_controller.sv
rtl/cmtc_checker.sv
test/tb.sv
